### src/i2cm_pkg.sv
package i2cm_pkg;

   localparam int DELAY_WIDTH_DEFAULT = 16;
   localparam int CSR_WIDTH = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CSR_WIDTH-1:0] SHORT_DELAY_RESET = 16'd10;
   localparam logic [CSR_WIDTH-1:0] LONG_DELAY_RESET = 16'd180;

   typedef enum logic [2:0] {
      CMD_START   = 3'd0,
      CMD_STOP    = 3'd1,
      CMD_WRITE   = 3'd2,
      CMD_READ    = 3'd3,
      CMD_ACK     = 3'd4,
      CMD_NACK    = 3'd5,
      CMD_WAITACK = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_CMD     = 2'd1,
      OP_BAD_CMD = 2'd2
   } op_type;

   typedef enum logic {
      CSR_SHORT_DELAY = 1'b0,
      CSR_LONG_DELAY  = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type     op;
      cmd_type    command;
      logic [7:0] write_data;
      logic       sda_in;
   } word_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_seen;
      logic       rejected;
   } res_type;

endpackage

### src/i2cm_front.sv
module i2cm_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic [2:0]           req_command,
   input  logic [7:0]           req_write_data,
   input  logic                 req_sda_in,
   input  logic                 wr_ready,
   output logic                 wr_valid,
   output i2cm_pkg::word_type   wr_word
);

   assign req_ready = wr_ready;
   assign wr_valid  = req_valid;

   // Sort the word into a tick, a known command or an unknown command code.
   always_comb begin
      wr_word.command    = i2cm_pkg::cmd_type'(req_command);
      wr_word.write_data = req_write_data;
      wr_word.sda_in     = req_sda_in;
      if (!req_kind) begin
         wr_word.op = i2cm_pkg::OP_TICK;
      end else if (req_command <= 3'(i2cm_pkg::CMD_WAITACK)) begin
         wr_word.op = i2cm_pkg::OP_CMD;
      end else begin
         wr_word.op = i2cm_pkg::OP_BAD_CMD;
      end
   end

endmodule

### src/i2cm_queue.sv
module i2cm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   output logic                 wr_ready,
   input  i2cm_pkg::word_type   wr_word,
   output logic                 rd_valid,
   input  logic                 rd_ready,
   output i2cm_pkg::word_type   rd_word
);

   i2cm_pkg::word_type store_ff [i2cm_pkg::QUEUE_DEPTH];
   logic [i2cm_pkg::QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [i2cm_pkg::QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [i2cm_pkg::QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic push, pop;

   assign wr_ready = (count_ff < i2cm_pkg::QUEUE_COUNT_WIDTH'(i2cm_pkg::QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_word  = store_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == i2cm_pkg::QUEUE_PTR_WIDTH'(i2cm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == i2cm_pkg::QUEUE_PTR_WIDTH'(i2cm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= wr_word;
      end
   end

endmodule

### src/i2cm_engine.sv
module i2cm_engine #(
   parameter int DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  i2cm_pkg::word_type     q_word,
   input  logic [DELAY_WIDTH-1:0] short_delay,
   input  logic [DELAY_WIDTH-1:0] long_delay,
   output logic                   res_valid,
   input  logic                   res_ready,
   output i2cm_pkg::res_type      res
);

   typedef struct packed {
      logic scl;
      logic sda;
      logic lng;
   } line_type;

   // Line change made on entry to a phase, and whether the long hold follows.
   function automatic line_type phase_change(input i2cm_pkg::cmd_type c,
                                             input logic [3:0] p, input logic msb,
                                             input logic scl, input logic sda);
      line_type r;
      r.scl = scl;
      r.sda = sda;
      r.lng = 1'b0;
      case (c)
         i2cm_pkg::CMD_START: begin
            if (p == 4'd0) r.sda = 1'b1;
            else if (p == 4'd1) r.scl = 1'b1;
            else if (p == 4'd2) r.sda = 1'b0;
            else r.scl = 1'b0;
         end
         i2cm_pkg::CMD_STOP: begin
            if (p == 4'd0) r.scl = 1'b0;
            else if (p == 4'd1) r.sda = 1'b0;
            else if (p == 4'd2) r.scl = 1'b1;
            else r.sda = 1'b1;
         end
         i2cm_pkg::CMD_ACK, i2cm_pkg::CMD_NACK: begin
            if (p == 4'd0) r.scl = 1'b0;
            else if (p == 4'd1) r.sda = (c == i2cm_pkg::CMD_NACK);
            else if (p == 4'd2) r.scl = 1'b1;
            else if (p == 4'd3) r.scl = 1'b0;
            else r.sda = 1'b1;
         end
         i2cm_pkg::CMD_WAITACK: begin
            if (p == 4'd0) r.scl = 1'b0;
            else if (p == 4'd1) r.sda = 1'b1;
            else if (p == 4'd2) r.scl = 1'b1;
            else begin
               r.scl = 1'b0;
               r.lng = 1'b1;
            end
         end
         i2cm_pkg::CMD_READ: begin
            r.scl = (p == 4'd1);
            r.lng = 1'b1;
         end
         default: begin
            if (p == 4'd0) r.scl = 1'b0;
            else if (p == 4'd1) r.sda = msb;
            else if (p == 4'd2) r.scl = 1'b1;
            else if (p == 4'd3) r.scl = 1'b0;
            else r.sda = 1'b1;
         end
      endcase
      return r;
   endfunction

   i2cm_pkg::cmd_type      cmd_ff, cmd_in;
   logic [3:0]             phase_ff, phase_in;
   logic [3:0]             bits_ff, bits_in;
   logic [DELAY_WIDTH-1:0] delay_ff, delay_in;
   logic [7:0]             shift_ff, shift_in;
   logic                   scl_line_ff, scl_line_in;
   logic                   sda_line_ff, sda_line_in;
   logic                   drive_ff, drive_in;
   logic                   ack_ff, ack_in;
   logic                   busy_ff, busy_in;
   logic [7:0]             hold_ff, hold_in;
   logic                   valid_ff, valid_in;
   i2cm_pkg::res_type      res_ff, res_in;
   logic                   pop;

   // The output register frees its slot in the same cycle it is taken.
   assign q_ready   = !valid_ff || res_ready;
   assign pop       = q_valid && q_ready;
   assign res_valid = valid_ff;
   assign res       = res_ff;

   always_comb begin
      line_type               lc;
      logic                   run;
      logic                   fin;
      logic                   done_v;
      logic                   rej_v;
      logic [DELAY_WIDTH-1:0] dsel;
      cmd_in      = cmd_ff;
      phase_in    = phase_ff;
      bits_in     = bits_ff;
      delay_in    = delay_ff;
      shift_in    = shift_ff;
      scl_line_in = scl_line_ff;
      sda_line_in = sda_line_ff;
      drive_in    = drive_ff;
      ack_in      = ack_ff;
      busy_in     = busy_ff;
      hold_in     = hold_ff;
      run         = 1'b0;
      fin         = 1'b0;
      done_v      = 1'b0;
      rej_v       = 1'b0;
      dsel        = '0;
      if (pop) begin
         case (q_word.op)
            i2cm_pkg::OP_CMD, i2cm_pkg::OP_BAD_CMD: begin
               if (busy_ff) begin
                  rej_v = 1'b1;
               end else if (q_word.op == i2cm_pkg::OP_CMD) begin
                  cmd_in   = q_word.command;
                  phase_in = 4'd0;
                  bits_in  = 4'd0;
                  shift_in = (q_word.command == i2cm_pkg::CMD_WRITE) ?
                             q_word.write_data : 8'd0;
                  drive_in = !(q_word.command == i2cm_pkg::CMD_READ ||
                               q_word.command == i2cm_pkg::CMD_WAITACK);
                  busy_in  = 1'b1;
                  run      = 1'b1;
               end
            end
            i2cm_pkg::OP_TICK: begin
               if (busy_ff) begin
                  delay_in = delay_ff - 1'b1;
                  if (delay_in == '0) begin
                     case (cmd_ff)
                        i2cm_pkg::CMD_READ: begin
                           if (phase_ff == 4'd0) begin
                              phase_in = 4'd1;
                              bits_in  = 4'd0;
                           end else if (phase_ff == 4'd1) begin
                              shift_in = {shift_ff[6:0], q_word.sda_in};
                              phase_in = 4'd2;
                           end else begin
                              bits_in = bits_ff + 1'b1;
                              if (bits_in >= 4'd8) begin
                                 hold_in = shift_ff;
                                 fin     = 1'b1;
                              end else begin
                                 phase_in = 4'd1;
                              end
                           end
                        end
                        i2cm_pkg::CMD_WRITE: begin
                           if (phase_ff == 4'd0) begin
                              phase_in = 4'd1;
                              bits_in  = 4'd0;
                           end else if (phase_ff == 4'd1 || phase_ff == 4'd2) begin
                              phase_in = phase_ff + 1'b1;
                           end else if (phase_ff == 4'd3) begin
                              shift_in = {shift_ff[6:0], 1'b0};
                              bits_in  = bits_ff + 1'b1;
                              phase_in = (bits_in >= 4'd8) ? 4'd4 : 4'd1;
                           end else begin
                              fin = 1'b1;
                           end
                        end
                        default: begin
                           if (cmd_ff == i2cm_pkg::CMD_WAITACK && phase_ff == 4'd2) begin
                              ack_in = !q_word.sda_in;
                           end
                           // Of the commands stepped here, only ack has a fifth phase that releases SDA.
                           if (phase_ff >= ((cmd_ff == i2cm_pkg::CMD_ACK) ? 4'd4 : 4'd3)) begin
                              fin = 1'b1;
                           end else begin
                              phase_in = phase_ff + 1'b1;
                           end
                        end
                     endcase
                     if (fin) begin
                        busy_in  = 1'b0;
                        done_v   = 1'b1;
                        phase_in = 4'd0;
                     end else begin
                        run = 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      lc = phase_change(cmd_in, phase_in, shift_in[7], scl_line_ff, sda_line_ff);
      if (run) begin
         scl_line_in = lc.scl;
         sda_line_in = lc.sda;
         dsel        = lc.lng ? long_delay : short_delay;
         delay_in    = (dsel == '0) ? DELAY_WIDTH'(1) : dsel;
      end
      res_in.scl_level = scl_line_in;
      res_in.sda_level = sda_line_in;
      res_in.sda_drive = drive_in;
      res_in.busy_res  = busy_in;
      res_in.done_res  = done_v;
      res_in.read_data = hold_in;
      res_in.ack_seen  = ack_in;
      res_in.rejected  = rej_v;
      valid_in = pop ? 1'b1 : (valid_ff && !res_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff      <= i2cm_pkg::CMD_START;
         phase_ff    <= '0;
         bits_ff     <= '0;
         delay_ff    <= '0;
         shift_ff    <= '0;
         scl_line_ff <= 1'b1;
         sda_line_ff <= 1'b1;
         drive_ff    <= 1'b1;
         ack_ff      <= 1'b0;
         busy_ff     <= 1'b0;
         hold_ff     <= '0;
         valid_ff    <= 1'b0;
      end else begin
         cmd_ff      <= cmd_in;
         phase_ff    <= phase_in;
         bits_ff     <= bits_in;
         delay_ff    <= delay_in;
         shift_ff    <= shift_in;
         scl_line_ff <= scl_line_in;
         sda_line_ff <= sda_line_in;
         drive_ff    <= drive_in;
         ack_ff      <= ack_in;
         busy_ff     <= busy_in;
         hold_ff     <= hold_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         res_ff <= res_in;
      end
   end

endmodule

### src/i2c_master_bit_engine.sv
// I2C master bit engine. Each word on the req_ channel is either one time tick
// (req_kind low) or a new command (req_kind high: start, stop, write byte, read
// byte, ack, nack, wait for ack). Every accepted word yields exactly one word
// on the rsp_ channel, in order, carrying the SCL/SDA levels, the SDA drive
// enable, busy and done flags, the last read byte, the last ack and a flag for
// a command that came in while a sequence was still running.
// Throughput is one word per clock cycle while rsp_ready is high. An accepted word
// passes through the two-word queue between the decoder and the sequencer and
// then through the output register before it shows up on rsp_. If rsp_ready
// is held low, the queue absorbs two more words before req_ready drops;
// nothing is lost or repeated.
// The APB-style port holds the short and long hold counts (byte addresses 0
// and 4, reset 10 and 180 ticks); write them only while the engine is idle.
// Synchronous reset puts both lines high with SDA driven, clears the queue,
// the sequencer state and the output valid flag.
module i2c_master_bit_engine #(
   parameter int DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_write_data,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_level,
   output logic        rsp_sda_level,
   output logic        rsp_sda_drive,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_ack_seen,
   output logic        rsp_rejected,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [i2cm_pkg::CSR_WIDTH-1:0] short_ff, short_in;
   logic [i2cm_pkg::CSR_WIDTH-1:0] long_ff, long_in;
   logic [31:0]                    short_ext, long_ext;
   logic                           csr_write;
   i2cm_pkg::csr_index_type        csr_index;

   logic               wr_valid, wr_ready, rd_valid, rd_ready;
   i2cm_pkg::word_type wr_word, rd_word;
   i2cm_pkg::res_type  res;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = i2cm_pkg::csr_index_type'(paddr[2]);

   always_comb begin
      short_in = short_ff;
      long_in  = long_ff;
      if (csr_write) begin
         case (csr_index)
            i2cm_pkg::CSR_SHORT_DELAY: short_in = pwdata[i2cm_pkg::CSR_WIDTH-1:0];
            i2cm_pkg::CSR_LONG_DELAY:  long_in  = pwdata[i2cm_pkg::CSR_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         i2cm_pkg::CSR_SHORT_DELAY: prdata = 32'(short_ff);
         i2cm_pkg::CSR_LONG_DELAY:  prdata = 32'(long_ff);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff <= i2cm_pkg::SHORT_DELAY_RESET;
         long_ff  <= i2cm_pkg::LONG_DELAY_RESET;
      end else begin
         short_ff <= short_in;
         long_ff  <= long_in;
      end
   end

   // The hold counts are cut or zero-extended to the counter width.
   assign short_ext = 32'(short_ff);
   assign long_ext  = 32'(long_ff);

   i2cm_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_command    (req_command),
      .req_write_data (req_write_data),
      .req_sda_in     (req_sda_in),
      .wr_ready       (wr_ready),
      .wr_valid       (wr_valid),
      .wr_word        (wr_word)
   );

   i2cm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (wr_valid),
      .wr_ready (wr_ready),
      .wr_word  (wr_word),
      .rd_valid (rd_valid),
      .rd_ready (rd_ready),
      .rd_word  (rd_word)
   );

   i2cm_engine #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (rd_valid),
      .q_ready     (rd_ready),
      .q_word      (rd_word),
      .short_delay (short_ext[DELAY_WIDTH-1:0]),
      .long_delay  (long_ext[DELAY_WIDTH-1:0]),
      .res_valid   (rsp_valid),
      .res_ready   (rsp_ready),
      .res         (res)
   );

   assign rsp_scl_level = res.scl_level;
   assign rsp_sda_level = res.sda_level;
   assign rsp_sda_drive = res.sda_drive;
   assign rsp_busy_res  = res.busy_res;
   assign rsp_done_res  = res.done_res;
   assign rsp_read_data = res.read_data;
   assign rsp_ack_seen  = res.ack_seen;
   assign rsp_rejected  = res.rejected;

   // A finished sequence leaves the engine idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while still busy");

   // A rejected command never disturbs the running sequence.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_busy_res)
      else $error("rejected command reported while idle");

   // Done comes from a tick, rejection from a command: never both at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_rejected)
      else $error("done and rejected in the same word");

endmodule

### test/i2c_master_bit_engine_checker.sv
module i2c_master_bit_engine_checker
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_kind,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_write_data,
   input  logic        req_sda_in,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_scl_level,
   input  logic        rsp_sda_level,
   input  logic        rsp_sda_drive,
   input  logic        rsp_busy_res,
   input  logic        rsp_done_res,
   input  logic [7:0]  rsp_read_data,
   input  logic        rsp_ack_seen,
   input  logic        rsp_rejected,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          error_count = 0,
   output int          pending_words = 0
);

   logic [CSR_WIDTH-1:0]           short_hold;
   logic [CSR_WIDTH-1:0]           long_hold;
   cmd_type                        seq_cmd;
   logic [3:0]                     seq_phase;
   logic [3:0]                     bit_index;
   logic [DELAY_WIDTH_DEFAULT-1:0] hold_count;
   logic [7:0]                     shift_reg;
   logic [7:0]                     read_byte;
   logic                           scl_q;
   logic                           sda_q;
   logic                           drive_q;
   logic                           ack_q;
   logic                           busy_q;
   res_type                        expected_words[$];

   task clear_engine();
      short_hold = SHORT_DELAY_RESET;
      long_hold = LONG_DELAY_RESET;
      seq_cmd = CMD_START;
      seq_phase = '0;
      bit_index = '0;
      hold_count = '0;
      shift_reg = '0;
      read_byte = '0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      drive_q = 1'b1;
      ack_q = 1'b0;
      busy_q = 1'b0;
   endtask

   // Applies the line change that opens the current phase and reloads the hold.
   task change_lines();
      bit                             use_long;
      logic [DELAY_WIDTH_DEFAULT-1:0] ticks;
      use_long = 1'b0;
      case (seq_cmd)
         CMD_START: begin
            case (seq_phase)
               4'd0: sda_q = 1'b1;
               4'd1: scl_q = 1'b1;
               4'd2: sda_q = 1'b0;
               default: scl_q = 1'b0;
            endcase
         end
         CMD_STOP: begin
            case (seq_phase)
               4'd0: scl_q = 1'b0;
               4'd1: sda_q = 1'b0;
               4'd2: scl_q = 1'b1;
               default: sda_q = 1'b1;
            endcase
         end
         CMD_ACK, CMD_NACK: begin
            case (seq_phase)
               4'd0: scl_q = 1'b0;
               4'd1: sda_q = (seq_cmd == CMD_NACK);
               4'd2: scl_q = 1'b1;
               4'd3: scl_q = 1'b0;
               default: sda_q = 1'b1;
            endcase
         end
         CMD_WAITACK: begin
            case (seq_phase)
               4'd0: scl_q = 1'b0;
               4'd1: sda_q = 1'b1;
               4'd2: scl_q = 1'b1;
               default: begin
                  scl_q = 1'b0;
                  use_long = 1'b1;
               end
            endcase
         end
         CMD_READ: begin
            scl_q = (seq_phase == 4'd1);
            use_long = 1'b1;
         end
         default: begin
            case (seq_phase)
               4'd0: scl_q = 1'b0;
               4'd1: sda_q = shift_reg[7];
               4'd2: scl_q = 1'b1;
               4'd3: scl_q = 1'b0;
               default: sda_q = 1'b1;
            endcase
         end
      endcase
      ticks = use_long ? long_hold : short_hold;
      hold_count = (ticks == '0) ? DELAY_WIDTH_DEFAULT'(1) : ticks;
   endtask

   // Steps the sequence once a hold has run out.
   task finish_hold(input logic sda, output bit seq_done);
      seq_done = 1'b0;
      case (seq_cmd)
         CMD_READ: begin
            if (seq_phase == 4'd0) begin
               seq_phase = 4'd1;
               bit_index = '0;
            end else if (seq_phase == 4'd1) begin
               shift_reg = {shift_reg[6:0], sda};
               seq_phase = 4'd2;
            end else begin
               bit_index = bit_index + 4'd1;
               if (bit_index >= 4'd8) begin
                  read_byte = shift_reg;
                  seq_done = 1'b1;
               end else begin
                  seq_phase = 4'd1;
               end
            end
         end
         CMD_WRITE: begin
            if (seq_phase == 4'd0) begin
               seq_phase = 4'd1;
               bit_index = '0;
            end else if (seq_phase == 4'd1 || seq_phase == 4'd2) begin
               seq_phase = seq_phase + 4'd1;
            end else if (seq_phase == 4'd3) begin
               shift_reg = {shift_reg[6:0], 1'b0};
               bit_index = bit_index + 4'd1;
               seq_phase = (bit_index >= 4'd8) ? 4'd4 : 4'd1;
            end else begin
               seq_done = 1'b1;
            end
         end
         default: begin
            if (seq_cmd == CMD_WAITACK && seq_phase == 4'd2) begin
               ack_q = !sda;
            end
            // Ack plays its closing SDA release; the others end after phase three.
            if (seq_phase >= ((seq_cmd == CMD_ACK) ? 4'd4 : 4'd3)) begin
               seq_done = 1'b1;
            end else begin
               seq_phase = seq_phase + 4'd1;
            end
         end
      endcase
   endtask

   task predict_word(input logic kind, input logic [2:0] cmd, input logic [7:0] data,
                     input logic sda);
      res_type want;
      bit      seq_done;
      want = '0;
      if (kind) begin
         if (busy_q) begin
            want.rejected = 1'b1;
         end else if (cmd <= CMD_WAITACK) begin
            seq_cmd = cmd_type'(cmd);
            seq_phase = '0;
            bit_index = '0;
            shift_reg = (seq_cmd == CMD_WRITE) ? data : 8'h00;
            drive_q = !(seq_cmd == CMD_READ || seq_cmd == CMD_WAITACK);
            busy_q = 1'b1;
            change_lines();
         end
      end else if (busy_q) begin
         hold_count = hold_count - 1'b1;
         if (hold_count == '0) begin
            finish_hold(sda, seq_done);
            if (seq_done) begin
               busy_q = 1'b0;
               want.done_res = 1'b1;
               seq_phase = '0;
            end else begin
               change_lines();
            end
         end
      end
      want.scl_level = scl_q;
      want.sda_level = sda_q;
      want.sda_drive = drive_q;
      want.busy_res = busy_q;
      want.read_data = read_byte;
      want.ack_seen = ack_q;
      expected_words.push_back(want);
   endtask

   task check_field(input string field, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endtask

   task compare_word();
      res_type want;
      if (expected_words.size() == 0) begin
         $display("%0t: result word with nothing expected, expected none, actual scl %b sda %b",
                  $time, rsp_scl_level, rsp_sda_level);
         error_count++;
      end else begin
         want = expected_words.pop_front();
         check_field("scl_level", 8'(want.scl_level), 8'(rsp_scl_level));
         check_field("sda_level", 8'(want.sda_level), 8'(rsp_sda_level));
         check_field("sda_drive", 8'(want.sda_drive), 8'(rsp_sda_drive));
         check_field("busy_res", 8'(want.busy_res), 8'(rsp_busy_res));
         check_field("done_res", 8'(want.done_res), 8'(rsp_done_res));
         check_field("read_data", want.read_data, rsp_read_data);
         check_field("ack_seen", 8'(want.ack_seen), 8'(rsp_ack_seen));
         check_field("rejected", 8'(want.rejected), 8'(rsp_rejected));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_engine();
         expected_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            compare_word();
         end
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (csr_index_type'(paddr[2]) == CSR_SHORT_DELAY) begin
                  short_hold = pwdata[CSR_WIDTH-1:0];
               end else begin
                  long_hold = pwdata[CSR_WIDTH-1:0];
               end
            end else begin
               check_field("prdata low", (csr_index_type'(paddr[2]) == CSR_SHORT_DELAY) ?
                           short_hold[7:0] : long_hold[7:0], prdata[7:0]);
               check_field("prdata high", (csr_index_type'(paddr[2]) == CSR_SHORT_DELAY) ?
                           short_hold[15:8] : long_hold[15:8], prdata[15:8]);
               check_field("prdata upper", 8'h00, prdata[31:24] | prdata[23:16]);
            end
         end
         if (req_valid && req_ready) begin
            predict_word(req_kind, req_command, req_write_data, req_sda_in);
         end
      end
      pending_words = expected_words.size();
   end

endmodule

### test/i2c_master_bit_engine_tb.sv
module i2c_master_bit_engine_tb;
   import i2cm_pkg::*;

   localparam logic       KIND_TICK   = 1'b0;
   localparam logic       KIND_CMD    = 1'b1;
   localparam logic [2:0] CMD_UNKNOWN = 3'd7;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_EVERY_THIRD,
      RX_RANDOM,
      RX_BURSTY
   } rx_pattern_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = 1'b0;
   logic [2:0]  req_command = '0;
   logic [7:0]  req_write_data = '0;
   logic        req_sda_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_scl_level;
   logic        rsp_sda_level;
   logic        rsp_sda_drive;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_read_data;
   logic        rsp_ack_seen;
   logic        rsp_rejected;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          error_count;
   int          pending_words;

   int             short_setting = int'(SHORT_DELAY_RESET);
   int             long_setting = int'(LONG_DELAY_RESET);
   int             burst_left = 0;
   int             sent_words = 0;
   int             pattern_cycle = 0;
   rx_pattern_type rx_pattern = RX_OPEN;

   i2c_master_bit_engine DUT (.*);

   i2c_master_bit_engine_checker line_check (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The receiver picks a new random stall pattern each time pattern_cycle wraps to zero.
   always @(negedge clock) begin
      if (pattern_cycle == 0) begin
         rx_pattern <= rx_pattern_type'($urandom_range(0, 3));
      end
      pattern_cycle <= (pattern_cycle == 47) ? 0 : pattern_cycle + 1;
      case (rx_pattern)
         RX_OPEN: rsp_ready <= 1'b1;
         RX_EVERY_THIRD: rsp_ready <= (pattern_cycle % 3 != 0);
         RX_RANDOM: rsp_ready <= ($urandom_range(0, 9) > 3);
         default: rsp_ready <= ((pattern_cycle % 16) < 11);
      endcase
   end

   initial begin
      #1000000;
      $display("i2c_master_bit_engine test failed");
      $finish;
   end

   // Ticks needed to play a whole command at the current hold settings.
   function automatic int sequence_ticks(input cmd_type c);
      int s;
      int l;
      s = (short_setting == 0) ? 1 : short_setting;
      l = (long_setting == 0) ? 1 : long_setting;
      case (c)
         CMD_START, CMD_STOP, CMD_NACK: return 4 * s;
         CMD_ACK: return 5 * s;
         CMD_WAITACK: return 3 * s + l;
         CMD_READ: return 17 * l;
         default: return 26 * s;
      endcase
   endfunction

   task automatic send_word(input logic kind, input logic [2:0] cmd, input logic [7:0] data,
                            input logic sda);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_valid = 1'b1;
      req_kind = kind;
      req_command = cmd;
      req_write_data = data;
      req_sda_in = sda;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      burst_left--;
      sent_words++;
   endtask

   task automatic send_tick(input logic sda);
      send_word(KIND_TICK, 3'($urandom_range(0, 7)), 8'($urandom), sda);
   endtask

   task automatic run_sequence(input cmd_type c, input logic [7:0] data, input bit sda_random,
                               input logic sda_fixed, input int intrude_pct);
      int n;
      n = sequence_ticks(c);
      send_word(KIND_CMD, c, data, 1'($urandom_range(0, 1)));
      for (int i = 0; i < n; i++) begin
         // A command while the sequence runs must be turned away.
         if ($urandom_range(0, 99) < intrude_pct) begin
            send_word(KIND_CMD, 3'($urandom_range(0, 7)), 8'($urandom),
                      1'($urandom_range(0, 1)));
         end
         send_tick(sda_random ? 1'($urandom_range(0, 1)) : sda_fixed);
      end
   endtask

   task automatic idle_noise();
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 1) == 0) begin
            send_tick(1'($urandom_range(0, 1)));
         end else begin
            send_word(KIND_CMD, CMD_UNKNOWN, 8'($urandom), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic random_phase(input int words, input logic [6:0] allowed);
      int      stop_at;
      cmd_type c;
      stop_at = sent_words + words;
      while (sent_words < stop_at) begin
         if ($urandom_range(0, 9) == 0) begin
            idle_noise();
         end else begin
            do c = cmd_type'($urandom_range(0, 6)); while (!allowed[c]);
            run_sequence(c, 8'($urandom), 1'b1, 1'b0, 4);
         end
      end
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      burst_left = 0;
      while (pending_words != 0) @(negedge clock);
   endtask

   task automatic csr_access(input csr_index_type idx, input bit is_write,
                             input logic [15:0] value);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = is_write;
      paddr = {idx, 2'b00};
      pwdata = {16'($urandom), value};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic set_holds(input int short_ticks, input int long_ticks);
      drain_results();
      csr_access(CSR_SHORT_DELAY, 1'b1, 16'(short_ticks));
      csr_access(CSR_LONG_DELAY, 1'b1, 16'(long_ticks));
      csr_access(CSR_SHORT_DELAY, 1'b0, 16'h0000);
      csr_access(CSR_LONG_DELAY, 1'b0, 16'h0000);
      short_setting = short_ticks;
      long_setting = long_ticks;
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Reset holds: idle tick, unknown code, then a start with commands cutting in.
      send_word(KIND_TICK, CMD_UNKNOWN, 8'hFF, 1'b1);
      send_word(KIND_CMD, CMD_UNKNOWN, 8'h00, 1'b0);
      run_sequence(CMD_START, 8'h00, 1'b1, 1'b0, 10);

      // Zero holds behave as one tick, which keeps every command short.
      set_holds(0, 0);
      run_sequence(CMD_START, 8'h00, 1'b1, 1'b0, 0);
      run_sequence(CMD_WRITE, 8'hFF, 1'b1, 1'b0, 0);
      run_sequence(CMD_WRITE, 8'h00, 1'b1, 1'b0, 0);
      run_sequence(CMD_WRITE, 8'hA5, 1'b1, 1'b0, 0);
      run_sequence(CMD_READ, 8'h00, 1'b0, 1'b1, 0);
      run_sequence(CMD_READ, 8'h00, 1'b0, 1'b0, 0);
      run_sequence(CMD_ACK, 8'h00, 1'b1, 1'b0, 0);
      run_sequence(CMD_NACK, 8'h00, 1'b1, 1'b0, 0);
      run_sequence(CMD_WAITACK, 8'h00, 1'b0, 1'b0, 0);
      run_sequence(CMD_WAITACK, 8'h00, 1'b0, 1'b1, 0);
      run_sequence(CMD_STOP, 8'h00, 1'b1, 1'b0, 0);

      set_holds(1, 1);
      random_phase(290, 7'h7F);
      set_holds($urandom_range(2, 3), $urandom_range(2, 4));
      random_phase(290, 7'h7F);

      // At the top hold values only commands that use the other hold are run.
      set_holds(1, 65535);
      random_phase(200, (7'd1 << CMD_START) | (7'd1 << CMD_STOP) | (7'd1 << CMD_WRITE) |
                        (7'd1 << CMD_ACK) | (7'd1 << CMD_NACK));
      set_holds(65535, 1);
      random_phase(150, 7'd1 << CMD_READ);

      drain_results();
      repeat (10) @(posedge clock);
      $display("Drove %0d words over six hold settings, from zero to the maximum.", sent_words);
      $display("Covered every command, rejected and unknown commands and idle ticks.");
      if (error_count == 0) begin
         $display("i2c_master_bit_engine test passed");
      end else begin
         $display("i2c_master_bit_engine test failed");
      end
      $finish;
   end

endmodule
